/* design/efsu_pkg.sv */
package efsu_pkg;

    typedef struct packed {
        logic signed [15:0] u_upper_left;
        logic signed [15:0] u_upper;
        logic signed [15:0] u_left;
        logic signed [15:0] u_here;
        logic signed [15:0] edge_east;
        logic signed [15:0] edge_west;
        logic signed [15:0] edge_north;
        logic signed [15:0] edge_south;
        logic signed [15:0] edge_north_west;
        logic signed [15:0] edge_north_east;
        logic signed [15:0] edge_south_west;
        logic signed [15:0] edge_south_east;
    } efsu_item_t;

    typedef struct packed {
        logic signed [15:0] edge_new;
        logic               saturated;
    } efsu_result_t;

    localparam logic [1:0] CFG_BETA    = 2'd0;
    localparam logic [1:0] CFG_LAMBDA  = 2'd1;
    localparam logic [1:0] CFG_EPSILON = 2'd2;

    localparam logic [11:0] BETA_RESET    = 12'd1024;
    localparam logic [16:0] LAMBDA_RESET  = 17'd655;
    localparam logic [11:0] EPSILON_RESET = 12'd2048;

    // sqrt(2)/2 in Q16
    localparam logic signed [17:0] DIAG_Q16 = 18'sd46341;
    // 4*(1+sqrt(2)/2)*2 in Q16
    localparam logic [19:0] LEFT_LE_Q16 = 20'd895016;

    localparam int DIV_STAGES = 16;

endpackage

/* design/edge_field_stencil_update.sv */
// Edge-field update, one pixel per transfer.
// item channel: item_valid/item_ready carry one stencil (four intensities,
// eight neighbor edge values). result channel: result_valid/result_ready
// carry the updated edge value and a saturation flag.
// cfg port: cfg_we writes cfg_data to the register chosen by cfg_index
// (0 beta, 1 lambda, 2 epsilon); write only while the pipeline is empty.
// Throughput: one item per cycle unless the stall below holds the pipeline.
// The 25 register stages are 8 arithmetic stages, 16 restoring-division
// stages (one quotient bit per stage) and the output register.
// Reset: pipeline empties, registers take beta 1024, lambda 655, eps 2048.
// Stall: while result_valid is high and result_ready low the whole pipeline
// holds and item_ready is low; nothing is lost or repeated.
module edge_field_stencil_update #(
    parameter int FRAC_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  efsu_pkg::efsu_item_t    item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output efsu_pkg::efsu_result_t  result,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [16:0]             cfg_data
);
    import efsu_pkg::*;

    localparam int NW = (57 + FRAC_BITS > 72) ? 57 + FRAC_BITS : 72;
    localparam int NSTG = 9 + DIV_STAGES;

    function automatic logic signed [17:0] sx18(input logic signed [15:0] x);
        return 18'(x);
    endfunction

    logic [11:0] beta_reg;
    logic [16:0] lambda_reg;
    logic [11:0] eps_reg;
    logic [11:0] eps_c;
    logic [23:0] p_reg, eps2_reg;
    logic [40:0] le2_reg;
    logic [60:0] lel_reg;
    logic [55:0] lq;

    logic [NSTG-1:0] vld_reg;
    logic adv;

    logic signed [16:0] s1_de_reg, s1_dw_reg, s1_dn_reg, s1_ds_reg;
    logic signed [16:0] s1_de_next, s1_dw_next, s1_dn_next, s1_ds_next;
    logic signed [17:0] s1_se4_reg, s1_sd4_reg, s1_se4_next, s1_sd4_next;
    logic signed [15:0] s1_ve_reg, s1_vw_reg, s1_vn_reg, s1_vs_reg;

    logic [31:0] s2_qe_reg, s2_qw_reg, s2_qn_reg, s2_qs_reg;
    logic [31:0] s2_qe_next, s2_qw_next, s2_qn_next, s2_qs_next;
    logic signed [36:0] s2_m_reg, s2_m_next;
    logic signed [15:0] s2_ve_reg, s2_vw_reg, s2_vn_reg, s2_vs_reg;

    logic signed [48:0] s3_we_reg, s3_ww_reg, s3_wn_reg, s3_ws_reg;
    logic signed [48:0] s3_we_next, s3_ww_next, s3_wn_next, s3_ws_next;
    logic [33:0] s3_sq_reg, s3_sq_next;
    logic [35:0] s3_mmag_reg, s3_mmag_next;
    logic s3_mneg_reg;

    logic signed [50:0] s4_wsum;
    logic [49:0] s4_wmag_reg, s4_wmag_next;
    logic s4_wneg_reg, s4_mneg_reg;
    logic [57:0] s4_pa_reg, s4_pa_next;
    logic [59:0] s4_mlo_reg, s4_mlo_next;
    logic [52:0] s4_mhi_reg, s4_mhi_next;

    logic [48:0] s5_wlo_reg, s5_whi_reg, s5_wlo_next, s5_whi_next;
    logic [79:0] s5_mfull;
    logic [55:0] s5_t2_reg, s5_t2_next;
    logic [41:0] s5_da_reg, s5_da_next;
    logic s5_wneg_reg, s5_mneg_reg;

    logic [79:0] s6_wfull;
    logic [55:0] s6_t1_reg, s6_t1_next, s6_t2_reg, s6_den_reg, s6_den_next;
    logic s6_wneg_reg, s6_mneg_reg;

    logic signed [57:0] s7_a, s7_b, s7_num_reg, s7_num_next;
    logic [55:0] s7_den_reg;

    logic [56:0] s8_mag;
    logic [NW-1:0] s8_n_reg, s8_n_next, s8_th_reg, s8_th_next;
    logic [55:0] s8_den_reg;
    logic s8_neg_reg, s8_zero_reg;

    logic [NW-1:0] rem_reg [DIV_STAGES];
    logic [NW-1:0] rem_next [DIV_STAGES];
    logic [15:0] q_reg [DIV_STAGES];
    logic [15:0] q_next [DIV_STAGES];
    logic [55:0] dd_reg [DIV_STAGES];
    logic sat_reg [DIV_STAGES];
    logic sat_next [DIV_STAGES];
    logic dneg_reg [DIV_STAGES];
    logic dzero_reg [DIV_STAGES];

    logic [15:0] out_val, out_lim;
    logic signed [15:0] edge_new_reg;
    logic saturated_reg;

    assign adv = !vld_reg[NSTG-1] || result_ready;
    assign item_ready = adv;
    assign result_valid = vld_reg[NSTG-1];
    assign result.edge_new = edge_new_reg;
    assign result.saturated = saturated_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= BETA_RESET;
            lambda_reg <= LAMBDA_RESET;
            eps_reg <= EPSILON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BETA:    beta_reg <= cfg_data[11:0];
                CFG_LAMBDA:  lambda_reg <= cfg_data;
                CFG_EPSILON: eps_reg <= cfg_data[11:0];
                default:     ;
            endcase
        end
    end

    assign eps_c = (eps_reg == 12'd0) ? 12'd1 : eps_reg;
    assign lq = 56'(lambda_reg) << (2 * FRAC_BITS - 16);

    always_ff @(posedge clk)
    begin
        p_reg <= 24'(beta_reg) * 24'(eps_c);
        eps2_reg <= 24'(eps_c) * 24'(eps_c);
        le2_reg <= 41'(lambda_reg) * 41'(eps2_reg);
        lel_reg <= 61'(le2_reg) * 61'(LEFT_LE_Q16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], item_valid};
    end

    always_comb
    begin
        s1_de_next = {item.u_here[15], item.u_here} - {item.u_upper[15], item.u_upper};
        s1_dw_next = {item.u_left[15], item.u_left}
                   - {item.u_upper_left[15], item.u_upper_left};
        s1_dn_next = {item.u_upper[15], item.u_upper}
                   - {item.u_upper_left[15], item.u_upper_left};
        s1_ds_next = {item.u_here[15], item.u_here} - {item.u_left[15], item.u_left};
        s1_se4_next = sx18(item.edge_east) + sx18(item.edge_west)
                    + sx18(item.edge_north) + sx18(item.edge_south);
        s1_sd4_next = sx18(item.edge_north_west) + sx18(item.edge_north_east)
                    + sx18(item.edge_south_west) + sx18(item.edge_south_east);
    end

    always_comb
    begin
        logic signed [33:0] pe, pw, pn, ps;
        pe = 34'(s1_de_reg) * 34'(s1_de_reg);
        pw = 34'(s1_dw_reg) * 34'(s1_dw_reg);
        pn = 34'(s1_dn_reg) * 34'(s1_dn_reg);
        ps = 34'(s1_ds_reg) * 34'(s1_ds_reg);
        s2_qe_next = pe[31:0];
        s2_qw_next = pw[31:0];
        s2_qn_next = pn[31:0];
        s2_qs_next = ps[31:0];
        s2_m_next = (37'(s1_se4_reg) <<< 16) + 37'(s1_sd4_reg) * 37'(DIAG_Q16);
    end

    always_comb
    begin
        s3_we_next = 49'(s2_ve_reg) * signed'(49'(s2_qe_reg));
        s3_ww_next = 49'(s2_vw_reg) * signed'(49'(s2_qw_reg));
        s3_wn_next = 49'(s2_vn_reg) * signed'(49'(s2_qn_reg));
        s3_ws_next = 49'(s2_vs_reg) * signed'(49'(s2_qs_reg));
        s3_sq_next = 34'(s2_qe_reg) + 34'(s2_qw_reg) + 34'(s2_qn_reg) + 34'(s2_qs_reg);
        s3_mmag_next = 36'(s2_m_reg[36] ? -s2_m_reg : s2_m_reg);
    end

    always_comb
    begin
        s4_wsum = 51'(s3_we_reg) + 51'(s3_ww_reg) + 51'(s3_wn_reg) + 51'(s3_ws_reg);
        s4_wmag_next = 50'(s4_wsum[50] ? -s4_wsum : s4_wsum);
        s4_pa_next = 58'(p_reg) * 58'(s3_sq_reg);
        s4_mlo_next = 60'(s3_mmag_reg) * 60'(le2_reg[23:0]);
        s4_mhi_next = 53'(s3_mmag_reg) * 53'(le2_reg[40:24]);
    end

    always_comb
    begin
        s5_wlo_next = 49'(s4_wmag_reg[24:0]) * 49'(p_reg);
        s5_whi_next = 49'(s4_wmag_reg[49:25]) * 49'(p_reg);
        s5_mfull = (80'(s4_mhi_reg) << 24) + 80'(s4_mlo_reg);
        s5_t2_next = 56'(s5_mfull >> (47 - FRAC_BITS));
        s5_da_next = 42'(s4_pa_reg >> 16);
    end

    always_comb
    begin
        s6_wfull = (80'(s5_whi_reg) << 25) + 80'(s5_wlo_reg);
        s6_t1_next = 56'(s6_wfull >> (16 + FRAC_BITS));
        s6_den_next = 56'(s5_da_reg) + 56'(lel_reg >> (48 - 2 * FRAC_BITS)) + lq;
    end

    always_comb
    begin
        s7_a = signed'(58'(s6_t1_reg));
        s7_b = signed'(58'(s6_t2_reg));
        s7_num_next = (s6_wneg_reg ? s7_a : -s7_a) + (s6_mneg_reg ? -s7_b : s7_b)
                    + signed'(58'(lq));
    end

    always_comb
    begin
        s8_mag = 57'(s7_num_reg[57] ? -s7_num_reg : s7_num_reg);
        s8_n_next = NW'(s8_mag) << FRAC_BITS;
        s8_th_next = (NW'(s7_den_reg) << 15) + (s7_num_reg[57] ? NW'(s7_den_reg) : '0);
    end

    // one quotient bit per stage, MSB first
    always_comb
    begin
        logic [NW-1:0] r_in, sh;
        logic [15:0] qi;
        logic [55:0] dv;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                r_in = s8_n_reg;
                qi = '0;
                dv = s8_den_reg;
                sat_next[j] = s8_n_reg >= s8_th_reg;
            end
            else
            begin
                r_in = rem_reg[j-1];
                qi = q_reg[j-1];
                dv = dd_reg[j-1];
                sat_next[j] = sat_reg[j-1];
            end
            sh = NW'(dv) << (DIV_STAGES - 1 - j);
            if (r_in >= sh)
            begin
                rem_next[j] = r_in - sh;
                q_next[j] = qi | (16'd1 << (DIV_STAGES - 1 - j));
            end
            else
            begin
                rem_next[j] = r_in;
                q_next[j] = qi;
            end
        end
    end

    always_comb
    begin
        out_lim = dneg_reg[DIV_STAGES-1] ? 16'h8000 : 16'h7FFF;
        if (dzero_reg[DIV_STAGES-1])
            out_val = '0;
        else if (sat_reg[DIV_STAGES-1])
            out_val = out_lim;
        else
            out_val = q_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_de_reg <= s1_de_next;
            s1_dw_reg <= s1_dw_next;
            s1_dn_reg <= s1_dn_next;
            s1_ds_reg <= s1_ds_next;
            s1_se4_reg <= s1_se4_next;
            s1_sd4_reg <= s1_sd4_next;
            s1_ve_reg <= item.edge_east;
            s1_vw_reg <= item.edge_west;
            s1_vn_reg <= item.edge_north;
            s1_vs_reg <= item.edge_south;

            s2_qe_reg <= s2_qe_next;
            s2_qw_reg <= s2_qw_next;
            s2_qn_reg <= s2_qn_next;
            s2_qs_reg <= s2_qs_next;
            s2_m_reg <= s2_m_next;
            s2_ve_reg <= s1_ve_reg;
            s2_vw_reg <= s1_vw_reg;
            s2_vn_reg <= s1_vn_reg;
            s2_vs_reg <= s1_vs_reg;

            s3_we_reg <= s3_we_next;
            s3_ww_reg <= s3_ww_next;
            s3_wn_reg <= s3_wn_next;
            s3_ws_reg <= s3_ws_next;
            s3_sq_reg <= s3_sq_next;
            s3_mmag_reg <= s3_mmag_next;
            s3_mneg_reg <= s2_m_reg[36];

            s4_wmag_reg <= s4_wmag_next;
            s4_wneg_reg <= s4_wsum[50];
            s4_pa_reg <= s4_pa_next;
            s4_mlo_reg <= s4_mlo_next;
            s4_mhi_reg <= s4_mhi_next;
            s4_mneg_reg <= s3_mneg_reg;

            s5_wlo_reg <= s5_wlo_next;
            s5_whi_reg <= s5_whi_next;
            s5_t2_reg <= s5_t2_next;
            s5_da_reg <= s5_da_next;
            s5_wneg_reg <= s4_wneg_reg;
            s5_mneg_reg <= s4_mneg_reg;

            s6_t1_reg <= s6_t1_next;
            s6_t2_reg <= s5_t2_reg;
            s6_den_reg <= s6_den_next;
            s6_wneg_reg <= s5_wneg_reg;
            s6_mneg_reg <= s5_mneg_reg;

            s7_num_reg <= s7_num_next;
            s7_den_reg <= s6_den_reg;

            s8_n_reg <= s8_n_next;
            s8_th_reg <= s8_th_next;
            s8_den_reg <= s7_den_reg;
            s8_neg_reg <= s7_num_reg[57];
            s8_zero_reg <= (s7_den_reg == 56'd0);

            for (int j = 0; j < DIV_STAGES; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j] <= q_next[j];
                sat_reg[j] <= sat_next[j];
                if (j == 0)
                begin
                    dd_reg[j] <= s8_den_reg;
                    dneg_reg[j] <= s8_neg_reg;
                    dzero_reg[j] <= s8_zero_reg;
                end
                else
                begin
                    dd_reg[j] <= dd_reg[j-1];
                    dneg_reg[j] <= dneg_reg[j-1];
                    dzero_reg[j] <= dzero_reg[j-1];
                end
            end

            edge_new_reg <= signed'(dneg_reg[DIV_STAGES-1] ? -out_val : out_val);
            saturated_reg <= sat_reg[DIV_STAGES-1] & ~dzero_reg[DIV_STAGES-1];
        end
    end

endmodule
